// ===== hdl/preemptive_priority_scheduler_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Included by the top level, which checks its own logic; no other dependencies.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// Invariant that holds at every edge out of reset.
`define PPS_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
  `PPS_ASSERT_IMP(label, clk, rstn, 1'b1, cond, msg)

`endif

// ===== hdl/pps_pkg.sv =====
// Shared types and constants of the preemptive priority scheduler.
// No dependencies; used by the interfaces, the cell and the top level.
package pps_pkg;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned PRIO_W = 8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // Process entry as written into one cell
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              load;
    logic              apply;
    logic [TIME_W-1:0] now;
    entry_t            entry;
  } cell_ctrl_t;

  // Best-candidate token that ripples down the cell row
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic              rem_one;
  } token_t;

endpackage

// ===== hdl/pps_if.sv =====
// Valid/ready channel interfaces for the scheduler input and result beats.
// Depends on pps_pkg for field widths.
interface pps_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [pps_pkg::ID_W-1:0]    proc_id;
  logic [pps_pkg::TIME_W-1:0]  arrival;
  logic [pps_pkg::TIME_W-1:0]  burst;
  logic [pps_pkg::PRIO_W-1:0]  prio;

  modport source (output valid, op, proc_id, arrival, burst, prio, input ready);
  modport sink   (input valid, op, proc_id, arrival, burst, prio, output ready);
endinterface

interface pps_out_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::TIME_W-1:0]  tick_end;
  logic                        idle;
  logic [pps_pkg::ID_W-1:0]    run_id;
  logic                        finished;
  logic [pps_pkg::TIME_W-1:0]  wait_time;
  logic [pps_pkg::TIME_W-1:0]  turnaround;
  logic                        all_done;

  modport source (output valid, tick_end, idle, run_id, finished, wait_time, turnaround,
                  all_done, input ready);
  modport sink   (input valid, tick_end, idle, run_id, finished, wait_time, turnaround,
                  all_done, output ready);
endinterface

// ===== hdl/pps_cell.sv =====
// One table slot of the scheduler: holds a process entry and compares it
// against the candidate token passing by. Depends on pps_pkg.
module pps_cell #(
  parameter int unsigned CNT_W    = 5,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pps_pkg::cell_ctrl_t ctrl_i,
  input  logic [CNT_W-1:0]    loaded_i,
  input  logic [IDX_W-1:0]    load_idx_i,
  input  logic [IDX_W-1:0]    win_idx_i,
  input  pps_pkg::token_t     tok_i,
  input  logic [IDX_W-1:0]    tok_idx_i,
  output pps_pkg::token_t     tok_o,
  output logic [IDX_W-1:0]    tok_idx_o
);
  import pps_pkg::*;

  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] arr_q;
  logic [TIME_W-1:0] burst_q;
  logic [PRIO_W-1:0] prio_q;
  logic [TIME_W-1:0] rem_q;
  logic              tok_valid_q;
  token_t            tok_q, tok_d;
  logic [IDX_W-1:0]  tok_idx_q, tok_idx_d;
  logic              elig, take, mine_load, mine_apply;

  assign mine_load  = ctrl_i.load  && (load_idx_i == IDX_W'(CELL_IDX));
  assign mine_apply = ctrl_i.apply && (win_idx_i  == IDX_W'(CELL_IDX));

  assign elig = (loaded_i > CNT_W'(CELL_IDX)) && (arr_q <= ctrl_i.now) && (rem_q != '0);
  // strict compare keeps the earlier slot on a tie
  assign take = elig && (!tok_i.found || (prio_q < tok_i.prio));

  always_comb begin
    tok_d     = tok_i;
    tok_idx_d = tok_idx_i;
    if (take) begin
      tok_d.found   = 1'b1;
      tok_d.prio    = prio_q;
      tok_d.id      = id_q;
      tok_d.arrival = arr_q;
      tok_d.burst   = burst_q;
      tok_d.rem_one = (rem_q == TIME_W'(1));
      tok_idx_d     = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mine_load) begin
      id_q    <= ctrl_i.entry.id;
      arr_q   <= ctrl_i.entry.arrival;
      burst_q <= ctrl_i.entry.burst;
      prio_q  <= ctrl_i.entry.prio;
      rem_q   <= ctrl_i.entry.burst;
    end else if (mine_apply) begin
      rem_q   <= rem_q - TIME_W'(1);
    end
    tok_q     <= tok_d;
    tok_idx_q <= tok_idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end
  assign tok_idx_o = tok_idx_q;

endmodule

// ===== hdl/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler.
// Input channel in_i: a load beat (op = load) appends a process entry to the
// table; it is dropped when all MAX_PROCS slots are taken. A tick beat
// (op = tick) runs the arrived, unfinished entry of lowest priority value
// (lowest slot on a tie) for one time unit and yields one result beat on
// out_o; a load beat yields none.
// Each slot is a cell in a row. A tick sends a candidate token down the row,
// one cell per cycle through a register in each cell; the winner is latched
// when the token leaves the row, and the result state then decrements it and
// writes the result register once it is free. The result beat becomes valid
// and in_i.ready rises in that same cycle, so a tick is accepted only after
// the result of the last one is written. A load beat writes its cell on accept.
// The result sits in an output register: a stalled receiver does not stop
// loads, and a following tick finishes its search and waits only for the
// register to drain.
// Reset empties the table and clears the time count; no clearing pass is needed.
// Depends on pps_pkg, pps_if, pps_cell and the assertion macro header.
module preemptive_priority_scheduler #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pps_in_if.sink    in_i,
  pps_out_if.source out_o
);
  import pps_pkg::*;
  `include "preemptive_priority_scheduler_macros.svh"

  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_PROCS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  loaded_q, done_q, done_d;
  logic [TIME_W-1:0] now_q, tick_end;
  token_t            win_q;
  logic [IDX_W-1:0]  win_idx_q;

  logic              out_valid_q;
  logic [TIME_W-1:0] out_tick_end_q, out_wait_q, out_tat_q;
  logic              out_idle_q, out_fin_q, out_all_done_q;
  logic [ID_W-1:0]   out_run_id_q;

  logic              in_acc, load_acc, tick_acc, full, out_free, commit, fin;
  logic [TIME_W-1:0] tat, wt;
  cell_ctrl_t        ctrl;

  token_t           tok   [MAX_PROCS+1];
  logic [IDX_W-1:0] tok_ix[MAX_PROCS+1];

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign full       = (loaded_q == CNT_W'(MAX_PROCS));
  assign load_acc   = in_acc && (in_i.op == OP_LOAD) && !full;
  assign tick_acc   = in_acc && (in_i.op == OP_TICK);

  assign out_free = !out_valid_q || out_o.ready;
  assign commit   = (state_q == ST_RESULT) && out_free;

  assign ctrl.load          = load_acc;
  assign ctrl.apply         = commit && win_q.found;
  assign ctrl.now           = now_q;
  assign ctrl.entry.id      = in_i.proc_id;
  assign ctrl.entry.arrival = in_i.arrival;
  assign ctrl.entry.burst   = in_i.burst;
  assign ctrl.entry.prio    = in_i.prio;

  // Seed the row with an empty candidate on each tick beat
  assign tok[0]    = '{valid: tick_acc, default: '0};
  assign tok_ix[0] = '0;

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    pps_cell #(
      .CNT_W    (CNT_W),
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .loaded_i   (loaded_q),
      .load_idx_i (loaded_q[IDX_W-1:0]),
      .win_idx_i  (win_idx_q),
      .tok_i      (tok[g]),
      .tok_idx_i  (tok_ix[g]),
      .tok_o      (tok[g+1]),
      .tok_idx_o  (tok_ix[g+1])
    );
  end

  assign tick_end = now_q + TIME_W'(1);
  assign fin      = win_q.found && win_q.rem_one;
  assign tat      = fin ? (tick_end - win_q.arrival) : '0;
  assign wt       = fin ? (tick_end - win_q.arrival - win_q.burst) : '0;
  assign done_d   = done_q + CNT_W'(fin);

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && tok[MAX_PROCS].valid) begin
      win_q     <= tok[MAX_PROCS];
      win_idx_q <= tok_ix[MAX_PROCS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      loaded_q       <= '0;
      done_q         <= '0;
      now_q          <= '0;
      out_valid_q    <= 1'b0;
      out_tick_end_q <= '0;
      out_idle_q     <= 1'b0;
      out_run_id_q   <= '0;
      out_fin_q      <= 1'b0;
      out_wait_q     <= '0;
      out_tat_q      <= '0;
      out_all_done_q <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (load_acc) begin
            loaded_q <= loaded_q + CNT_W'(1);
            // a zero burst counts as finished at once
            if (in_i.burst == '0) begin
              done_q <= done_q + CNT_W'(1);
            end
          end
          if (tick_acc) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tok[MAX_PROCS].valid) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (commit) begin
            out_tick_end_q <= tick_end;
            out_idle_q     <= !win_q.found;
            out_run_id_q   <= win_q.found ? win_q.id : '0;
            out_fin_q      <= fin;
            out_wait_q     <= wt;
            out_tat_q      <= tat;
            out_all_done_q <= (done_d == loaded_q);
            done_q         <= done_d;
            now_q          <= tick_end;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.tick_end   = out_tick_end_q;
  assign out_o.idle       = out_idle_q;
  assign out_o.run_id     = out_run_id_q;
  assign out_o.finished   = out_fin_q;
  assign out_o.wait_time  = out_wait_q;
  assign out_o.turnaround = out_tat_q;
  assign out_o.all_done   = out_all_done_q;

  `PPS_ASSERT_ALWAYS(a_done_le_loaded, clk_i, rst_ni, done_q <= loaded_q,
    "more entries finished than loaded")
  `PPS_ASSERT_ALWAYS(a_loaded_le_max, clk_i, rst_ni, loaded_q <= CNT_W'(MAX_PROCS),
    "table fill count beyond capacity")
  `PPS_ASSERT_IMP(a_token_in_scan, clk_i, rst_ni, tok[MAX_PROCS].valid, state_q == ST_SCAN,
    "search token left the row outside a scan")
  `PPS_ASSERT_NXT(a_commit_beat, clk_i, rst_ni, commit, out_valid_q && (now_q == $past(tick_end)),
    "result beat not written with the advanced time")
  `PPS_ASSERT_IMP(a_finish_runs, clk_i, rst_ni, out_valid_q && out_fin_q, !out_idle_q,
    "idle tick reported a finished process")

endmodule
